// ===== hw/rtl/bmf_pkg.sv =====
// Package: shared constants, types and fixed-point helpers for the MF SGD block
`default_nettype none
package bmf_pkg;
	localparam int USER_ROWS   = 1024;
	localparam int ITEM_ROWS   = 1024;
	localparam int MAX_FACTORS = 16;
	localparam int UW  = $clog2(USER_ROWS);
	localparam int IW  = $clog2(ITEM_ROWS);
	localparam int FW  = $clog2(MAX_FACTORS);
	localparam int UAW = UW + FW;
	localparam int IAW = IW + FW;
	localparam int CLR_ROWS = (USER_ROWS > ITEM_ROWS) ? USER_ROWS : ITEM_ROWS;
	localparam int CW  = $clog2(CLR_ROWS);

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_TRAIN   = 2'd1;
	localparam logic [1:0] KIND_PREDICT = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	localparam logic [2:0] REG_ALPHA  = 3'd0;
	localparam logic [2:0] REG_LAMBDA = 3'd1;
	localparam logic [2:0] REG_NF     = 3'd2;
	localparam logic [2:0] REG_USERS  = 3'd3;
	localparam logic [2:0] REG_ITEMS  = 3'd4;

	// multiplier operand select
	typedef enum logic [2:0] {
		M_UV, M_DECAY, M_DELTA, M_GRAD_U, M_GRAD_V, M_SQ, M_RES
	} mop_t;

	// adder operand select
	typedef enum logic [2:0] {
		A_BIAS, A_PRED, A_RES, A_DIFF, A_MOVE
	} aop_t;

	// datapath register write select
	typedef enum logic [3:0] {
		W_NONE, W_UB, W_IB, W_UF, W_IF, W_PRED, W_RES, W_PROD, W_DIFF, W_ACC,
		W_GRAD
	} wsel_t;

	typedef struct packed {
		logic       clr;
		logic       rd_bias;
		logic       rd_fac;
		logic [FW-1:0] slot;
		mop_t       mop;
		aop_t       aop;
		logic       sel_w_user;
		logic       sel_w_bias;
		wsel_t      wsel;
		logic       wr_ub;
		logic       wr_ib;
		logic       wr_uf;
		logic       wr_if;
		logic       sq_cap;
		logic       init_wr;
		logic [CW-1:0] init_row;
	} cmd_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] x, output logic s);
		logic signed [63:0] mx, mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		s = 1'b0;
		if (x > mx) begin
			s = 1'b1;
			sat32 = 32'h7fffffff;
		end else if (x < mn) begin
			s = 1'b1;
			sat32 = 32'h80000000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/bmf_dp.sv =====
// Datapath: factor and bias memories, one multiplier, one saturating adder
`default_nettype none
module bmf_dp import bmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic        ld_en,
	input  wire logic        ld_tbl,
	input  wire logic [UW-1:0] ld_row,
	input  wire logic [FW-1:0] ld_slot,
	input  wire logic [31:0] ld_val,
	input  wire logic [UW-1:0] ui,
	input  wire logic [IW-1:0] ii,
	input  wire logic [31:0] rating,
	input  wire logic [15:0] alpha,
	input  wire logic [15:0] lambda,
	output logic      [31:0] pred,
	output logic      [31:0] res,
	output logic      [31:0] sq,
	output logic             sat
);
	logic [31:0] uf_mem [USER_ROWS*MAX_FACTORS];
	logic [31:0] if_mem [ITEM_ROWS*MAX_FACTORS];
	logic [31:0] ub_mem [USER_ROWS];
	logic [31:0] ib_mem [ITEM_ROWS];

	logic [31:0] uf_rd_q, if_rd_q, ub_rd_q, ib_rd_q;
	logic [31:0] u_q, v_q, ubias_q, ibias_q, pred_q, res_q, prod_q, diff_q, acc_q, grad_q;
	logic [31:0] sq_q;
	logic        sat_q;

	logic [UAW-1:0] ua;
	logic [IAW-1:0] ia;
	assign ua = {ui, cmd.slot};
	assign ia = {ii, cmd.slot};

	logic [31:0] wval;
	assign wval = acc_q;

	always_ff @(posedge clk) begin
		if (ld_en && !ld_tbl) uf_mem[{ld_row, ld_slot}] <= ld_val;
		else if (cmd.wr_uf) uf_mem[ua] <= wval;
		if (ld_en && ld_tbl) if_mem[{ld_row[IW-1:0], ld_slot}] <= ld_val;
		else if (cmd.wr_if) if_mem[ia] <= wval;
		if (cmd.init_wr) begin
			if (int'(cmd.init_row) < USER_ROWS) ub_mem[cmd.init_row[UW-1:0]] <= '0;
		end else if (cmd.wr_ub) begin
			ub_mem[ui] <= wval;
		end
		if (cmd.init_wr) begin
			if (int'(cmd.init_row) < ITEM_ROWS) ib_mem[cmd.init_row[IW-1:0]] <= '0;
		end else if (cmd.wr_ib) begin
			ib_mem[ii] <= wval;
		end
		if (cmd.rd_fac) begin
			uf_rd_q <= uf_mem[ua];
			if_rd_q <= if_mem[ia];
		end
		if (cmd.rd_bias) begin
			ub_rd_q <= ub_mem[ui];
			ib_rd_q <= ib_mem[ii];
		end
	end

	logic [31:0] ubias_rd, ibias_rd;
	assign ubias_rd = ub_rd_q;
	assign ibias_rd = ib_rd_q;

	// multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic [31:0] msat;
	logic        ms;
	logic [31:0] w_sel;
	assign w_sel = cmd.sel_w_bias ? (cmd.sel_w_user ? ubias_q : ibias_q)
	                              : (cmd.sel_w_user ? u_q : v_q);
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mop)
			M_UV:     begin ma = u_q;    mb = v_q; end
			M_DECAY:  begin ma = w_sel;  mb = $signed({16'd0, lambda}); end
			M_DELTA:  begin ma = diff_q; mb = $signed({16'd0, alpha}); end
			M_GRAD_U: begin ma = res_q;  mb = v_q; end
			M_GRAD_V: begin ma = res_q;  mb = u_q; end
			M_SQ:     begin ma = res_q;  mb = res_q; end
			M_RES:    begin ma = res_q;  mb = 32'sd65536; end
			default:  begin ma = '0;     mb = '0; end
		endcase
		mp = ma * mb;
		msat = sat32(mp >>> 16, ms);
	end

	// adder
	logic signed [63:0] aa, ab, as_;
	logic [31:0] asat;
	logic        ass;
	always_comb begin
		aa = '0;
		ab = '0;
		case (cmd.aop)
			A_BIAS: begin aa = 64'($signed(ubias_q)); ab = 64'($signed(ibias_q)); end
			A_PRED: begin aa = 64'($signed(pred_q)); ab = 64'($signed(prod_q)); end
			A_RES:  begin aa = 64'($signed(rating)); ab = -64'($signed(pred_q)); end
			A_DIFF: begin aa = 64'($signed(grad_q)); ab = -64'($signed(prod_q)); end
			A_MOVE: begin aa = 64'($signed(w_sel)); ab = 64'($signed(prod_q)); end
			default: begin aa = '0; ab = '0; end
		endcase
		as_ = aa + ab;
		asat = sat32(as_, ass);
	end

	logic sq_big;
	assign sq_big = (mp[63:48] != 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.clr) begin
			sat_q <= 1'b0;
		end else begin
			case (cmd.wsel)
				W_PROD, W_GRAD: sat_q <= sat_q | ms;
				W_PRED, W_RES, W_DIFF, W_ACC: sat_q <= sat_q | ass;
				default: ;
			endcase
			if (cmd.sq_cap) sat_q <= sat_q | sq_big;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			pred_q <= '0;
			res_q <= '0;
			sq_q <= '0;
		end else begin
			case (cmd.wsel)
				W_UB:   ubias_q <= ubias_rd;
				W_IB:   ibias_q <= ibias_rd;
				W_UF:   begin u_q <= uf_rd_q; v_q <= if_rd_q; end
				W_PRED: pred_q <= asat;
				W_RES:  res_q <= asat;
				W_PROD: prod_q <= msat;
				W_GRAD: grad_q <= msat;
				W_DIFF: diff_q <= asat;
				W_ACC:  acc_q <= asat;
				default: ;
			endcase
			if (cmd.wsel == W_UB) ibias_q <= ibias_rd;
			if (cmd.sq_cap) sq_q <= sq_big ? 32'hffffffff : mp[47:16];
		end
	end

	assign pred = pred_q;
	assign res  = res_q;
	assign sq   = sq_q;
	assign sat  = sat_q;
endmodule
`default_nettype wire

// ===== hw/rtl/bmf_ctrl.sv =====
// Controller: sequences predict and train requests over the datapath
`default_nettype none
module bmf_ctrl import bmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic        is_train,
	input  wire logic        oor,
	input  wire logic [4:0]  nf,
	input  wire logic        out_free,
	output cmd_t             cmd,
	output logic             busy,
	output logic             done
);
	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_RDB, S_LB, S_BSUM, S_FRD, S_FLD, S_FMUL, S_FADD,
		S_RES, S_SQ,
		S_BDEC, S_BDIFF, S_BDEL, S_BMOVE, S_BWR,
		S_URD, S_ULD, S_UGR, S_UDEC, S_UDIFF, S_UDEL, S_UMOVE, S_UWR,
		S_VGR, S_VDEC, S_VDIFF, S_VDEL, S_VMOVE, S_VWR,
		S_OUT
	} st_t;

	st_t st_q;
	logic [FW:0] k_q;
	logic [CW-1:0] init_q;
	logic        bu_q;
	logic        tr_q;
	logic        bwr_q, bwr_u_q;
	logic [FW:0] nfe;
	assign nfe = (nf > 5'(MAX_FACTORS)) ? (FW+1)'(MAX_FACTORS) : nf[FW:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
			k_q <= '0;
			init_q <= '0;
			bu_q <= 1'b0;
			tr_q <= 1'b0;
		end else begin
			case (st_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == CW'(CLR_ROWS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (go) begin
					tr_q <= is_train;
					st_q <= oor ? S_OUT : S_RDB;
				end
				S_RDB:  st_q <= S_LB;
				S_LB:   st_q <= S_BSUM;
				S_BSUM: begin
					k_q <= '0;
					st_q <= (nfe == '0) ? (tr_q ? S_RES : S_OUT) : S_FRD;
				end
				S_FRD:  st_q <= S_FLD;
				S_FLD:  st_q <= S_FMUL;
				S_FMUL: st_q <= S_FADD;
				S_FADD: begin
					k_q <= k_q + 1'b1;
					st_q <= (k_q + 1'b1 == nfe) ? (tr_q ? S_RES : S_OUT) : S_FRD;
				end
				S_RES:  st_q <= S_SQ;
				S_SQ:   begin bu_q <= 1'b1; st_q <= S_BDEC; end
				S_BDEC: st_q <= S_BDIFF;
				S_BDIFF: st_q <= S_BDEL;
				S_BDEL: st_q <= S_BMOVE;
				S_BMOVE: st_q <= S_BWR;
				S_BWR: begin
					bu_q <= 1'b0;
					k_q <= '0;
					if (bu_q) st_q <= S_BDEC;
					else st_q <= (nfe == '0) ? S_OUT : S_URD;
				end
				S_URD:  st_q <= S_ULD;
				S_ULD:  st_q <= S_UGR;
				S_UGR:  st_q <= S_UDEC;
				S_UDEC: st_q <= S_UDIFF;
				S_UDIFF: st_q <= S_UDEL;
				S_UDEL: st_q <= S_UMOVE;
				S_UMOVE: st_q <= S_UWR;
				S_UWR:  st_q <= S_VGR;
				S_VGR:  st_q <= S_VDEC;
				S_VDEC: st_q <= S_VDIFF;
				S_VDIFF: st_q <= S_VDEL;
				S_VDEL: st_q <= S_VMOVE;
				S_VMOVE: st_q <= S_VWR;
				S_VWR: begin
					k_q <= k_q + 1'b1;
					st_q <= (k_q + 1'b1 == nfe) ? S_OUT : S_URD;
				end
				S_OUT:  if (out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// bias write lands in the cycle after S_BWR computes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bwr_q <= 1'b0;
			bwr_u_q <= 1'b0;
		end else begin
			bwr_q <= (st_q == S_BWR);
			bwr_u_q <= bu_q;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mop = M_UV;
		cmd.aop = A_BIAS;
		cmd.wsel = W_NONE;
		cmd.slot = k_q[FW-1:0];
		case (st_q)
			S_IDLE:  cmd.clr = go;
			S_RDB:   cmd.rd_bias = 1'b1;
			S_LB:    cmd.wsel = W_UB;
			S_BSUM:  begin cmd.aop = A_BIAS; cmd.wsel = W_PRED; end
			S_FRD, S_URD: cmd.rd_fac = 1'b1;
			S_FLD, S_ULD: cmd.wsel = W_UF;
			S_FMUL:  begin cmd.mop = M_UV; cmd.wsel = W_PROD; end
			S_FADD:  begin cmd.aop = A_PRED; cmd.wsel = W_PRED; end
			S_RES:   begin cmd.aop = A_RES; cmd.wsel = W_RES; end
			S_SQ:    begin cmd.mop = M_SQ; cmd.sq_cap = 1'b1; end
			S_BDEC:  begin
				cmd.wsel = W_GRAD; cmd.mop = M_RES;
			end
			S_BDIFF: begin
				cmd.sel_w_bias = 1'b1; cmd.sel_w_user = bu_q;
				cmd.mop = M_DECAY; cmd.wsel = W_PROD;
			end
			S_BDEL:  begin cmd.aop = A_DIFF; cmd.wsel = W_DIFF; end
			S_BMOVE: begin cmd.mop = M_DELTA; cmd.wsel = W_PROD; end
			S_BWR:   begin
				cmd.sel_w_bias = 1'b1; cmd.sel_w_user = bu_q;
				cmd.aop = A_MOVE; cmd.wsel = W_ACC;
			end
			S_UGR:   begin cmd.mop = M_GRAD_U; cmd.wsel = W_GRAD; end
			S_UDEC:  begin cmd.sel_w_user = 1'b1; cmd.mop = M_DECAY; cmd.wsel = W_PROD; end
			S_UDIFF: begin cmd.aop = A_DIFF; cmd.wsel = W_DIFF; end
			S_UDEL:  begin cmd.mop = M_DELTA; cmd.wsel = W_PROD; end
			S_UMOVE: begin cmd.sel_w_user = 1'b1; cmd.aop = A_MOVE; cmd.wsel = W_ACC; end
			S_UWR:   cmd.wr_uf = 1'b1;
			S_VGR:   begin cmd.mop = M_GRAD_V; cmd.wsel = W_GRAD; end
			S_VDEC:  begin cmd.mop = M_DECAY; cmd.wsel = W_PROD; end
			S_VDIFF: begin cmd.aop = A_DIFF; cmd.wsel = W_DIFF; end
			S_VDEL:  begin cmd.mop = M_DELTA; cmd.wsel = W_PROD; end
			S_VMOVE: begin cmd.aop = A_MOVE; cmd.wsel = W_ACC; end
			S_VWR:   cmd.wr_if = 1'b1;
			default: ;
		endcase
		cmd.wr_ub = bwr_q && bwr_u_q;
		cmd.wr_ib = bwr_q && !bwr_u_q;
		cmd.init_wr = (st_q == S_INIT);
		cmd.init_row = init_q;
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_OUT);
endmodule
`default_nettype wire

// ===== hw/rtl/biased_mf_sgd_step.sv =====
// Top level: biased matrix factorisation SGD step block
//
// Requests arrive on in_valid/in_ready. A load request writes one factor
// element at its acceptance and gives no result; loads can follow back to
// back. Predict and train requests give one result on out_valid/out_ready.
// The factors in use number up to 16; one shared multiplier and one
// saturating adder are stepped by the controller, one operation per cycle.
// An out-of-range request gives its flagged result in the cycle after
// acceptance. The next request is taken in the cycle after the result leaves.
// Reset restores the configuration defaults, then the block clears both bias
// tables with in_ready low; factor tables hold nothing until loaded.
// While a result waits for out_ready the block holds it and accepts no
// further request. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
`default_nettype none
module biased_mf_sgd_step import bmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [9:0]  user_index,
	input  wire logic [9:0]  item_index,
	input  wire logic [31:0] rating,
	input  wire logic        load_table,
	input  wire logic [3:0]  factor_slot,
	input  wire logic [31:0] factor_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] prediction,
	output logic      [31:0] residual,
	output logic      [31:0] squared_residual,
	output logic             out_of_range,
	output logic             saturated
);
	logic [15:0] alpha_q, lambda_q;
	logic [4:0]  nf_q;
	logic [10:0] users_q, items_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd655;
			lambda_q <= 16'd1311;
			nf_q <= 5'd16;
			users_q <= 11'd1024;
			items_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA:  alpha_q <= cfg_data;
				REG_LAMBDA: lambda_q <= cfg_data;
				REG_NF:     nf_q <= cfg_data[4:0];
				REG_USERS:  users_q <= cfg_data[10:0];
				REG_ITEMS:  items_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// request registers
	logic [UW-1:0] ui_q;
	logic [IW-1:0] ii_q;
	logic [31:0]   rating_q;
	logic          oor_q;

	logic busy, acc, is_op, oor_in;
	assign in_ready = !busy;
	assign acc = in_valid && in_ready;
	assign is_op = (kind == KIND_TRAIN) || (kind == KIND_PREDICT);
	assign oor_in = ({1'b0, user_index} >= users_q) || ({1'b0, item_index} >= items_q);

	always_ff @(posedge clk) begin
		if (acc) begin
			ui_q <= user_index;
			ii_q <= item_index;
			rating_q <= rating;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) oor_q <= 1'b0;
		else if (acc && is_op) oor_q <= oor_in;
	end

	cmd_t c_cmd;
	logic [31:0] p, r, s;
	logic sat;

	bmf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(acc && is_op),
		.is_train(kind == KIND_TRAIN), .oor(oor_in), .nf(nf_q),
		.out_free(out_ready), .cmd(c_cmd), .busy(busy), .done(out_valid)
	);

	bmf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(c_cmd),
		.ld_en(acc && kind == KIND_LOAD), .ld_tbl(load_table), .ld_row(user_index),
		.ld_slot(factor_slot), .ld_val(factor_value),
		.ui(ui_q), .ii(ii_q), .rating(rating_q), .alpha(alpha_q), .lambda(lambda_q),
		.pred(p), .res(r), .sq(s), .sat(sat)
	);

	assign prediction = p;
	assign residual = r;
	assign squared_residual = s;
	assign out_of_range = oor_q;
	assign saturated = sat;

`ifndef SYNTHESIS
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("ready while busy");
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (prediction == '0 && !saturated))
		else $error("out of range result not zero");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid) else $error("result repeated");
`endif
endmodule
`default_nettype wire

// ===== dv/biased_mf_sgd_step_tb.sv =====
// Testbench for biased_mf_sgd_step: directed and random requests checked against a predictor
`timescale 1ns / 100ps
module biased_mf_sgd_step_tb import bmf_pkg::*; ();

	typedef struct {
		logic [1:0]  kind;
		logic [9:0]  ui;
		logic [9:0]  ii;
		logic [31:0] rating;
		logic        tbl;
		logic [3:0]  slot;
		logic [31:0] fval;
	} req_t;

	typedef struct {
		logic [31:0] pred;
		logic [31:0] res;
		logic [31:0] sq;
		logic        oor;
		logic        sat;
	} rating_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic [9:0]  user_index = '0;
	logic [9:0]  item_index = '0;
	logic [31:0] rating = '0;
	logic        load_table = 1'b0;
	logic [3:0]  factor_slot = '0;
	logic [31:0] factor_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] prediction;
	logic [31:0] residual;
	logic [31:0] squared_residual;
	logic        out_of_range;
	logic        saturated;

	biased_mf_sgd_step dut (.*);

	always #4 clk = ~clk;

	int unsigned alpha = 655, lambda = 1311, nf_cfg = 16, users_cfg = 1024, items_cfg = 1024;
	int ufac[USER_ROWS*MAX_FACTORS];
	int ifac[ITEM_ROWS*MAX_FACTORS];
	int ubias[USER_ROWS];
	int ibias[ITEM_ROWS];

	req_t        pending_reqs[$];
	rating_out_t expected_ratings[$];
	req_t        cur;
	int          accepted = 0, results_seen = 0, errors = 0, trains = 0;
	int          rows[6] = '{0, 1, 2, 341, 682, 1023};

	function automatic int clamp(longint x, inout bit s);
		if (x > 64'sd2147483647) begin
			s = 1;
			return 32'h7fffffff;
		end
		if (x < -64'sd2147483648) begin
			s = 1;
			return 32'h80000000;
		end
		return int'(x);
	endfunction

	function automatic int fx_mul(int a, int b, inout bit s);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp(p >>> 16, s);
	endfunction

	function automatic int sgd_move(int w, int g, inout bit s);
		int decay, diff, delta;
		decay = fx_mul(w, int'(lambda), s);
		diff = clamp(longint'(g) - longint'(decay), s);
		delta = fx_mul(diff, int'(alpha), s);
		return clamp(longint'(w) + longint'(delta), s);
	endfunction

	function automatic bit rate_step(req_t r, output rating_out_t o);
		int unsigned ulim, ilim, nf, ub, ib;
		int pred, res, u_old, v_old;
		longint e2;
		bit s;
		s = 0;
		o = '{default: '0};
		if (r.kind == KIND_LOAD) begin
			if (r.tbl == 1'b0) ufac[r.ui*MAX_FACTORS + r.slot] = r.fval;
			else ifac[r.ui*MAX_FACTORS + r.slot] = r.fval;
			return 0;
		end
		if (r.kind != KIND_TRAIN && r.kind != KIND_PREDICT) return 0;
		ulim = users_cfg < USER_ROWS ? users_cfg : USER_ROWS;
		ilim = items_cfg < ITEM_ROWS ? items_cfg : ITEM_ROWS;
		if (r.ui >= ulim || r.ii >= ilim) begin
			o.oor = 1'b1;
			return 1;
		end
		nf = nf_cfg < MAX_FACTORS ? nf_cfg : MAX_FACTORS;
		ub = r.ui * MAX_FACTORS;
		ib = r.ii * MAX_FACTORS;
		pred = clamp(longint'(ubias[r.ui]) + longint'(ibias[r.ii]), s);
		for (int k = 0; k < nf; k++)
			pred = clamp(longint'(pred) + longint'(fx_mul(ufac[ub+k], ifac[ib+k], s)), s);
		res = 0;
		if (r.kind == KIND_TRAIN) begin
			res = clamp(longint'(int'(r.rating)) - longint'(pred), s);
			e2 = (longint'(res) * longint'(res)) >>> 16;
			if (e2 > 64'sd4294967295) begin
				s = 1;
				o.sq = 32'hffffffff;
			end else begin
				o.sq = e2[31:0];
			end
			ubias[r.ui] = sgd_move(ubias[r.ui], res, s);
			ibias[r.ii] = sgd_move(ibias[r.ii], res, s);
			for (int k = 0; k < nf; k++) begin
				u_old = ufac[ub+k];
				v_old = ifac[ib+k];
				ufac[ub+k] = sgd_move(u_old, fx_mul(res, v_old, s), s);
				ifac[ib+k] = sgd_move(v_old, fx_mul(res, u_old, s), s);
			end
		end
		o.pred = pred;
		o.res = res;
		o.sat = s;
		return 1;
	endfunction

	function automatic bit stall();
		if (accepted >= 400 && accepted < 650) return 0;
		return $urandom_range(99) < 17;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rating_out_t o;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				accepted++;
				if (rate_step(cur, o)) expected_ratings.push_back(o);
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_reqs.size() > 0 && !stall()) begin
					cur = pending_reqs.pop_front();
					in_valid <= 1'b1;
					kind <= cur.kind;
					user_index <= cur.ui;
					item_index <= cur.ii;
					rating <= cur.rating;
					load_table <= cur.tbl;
					factor_slot <= cur.slot;
					factor_value <= cur.fval;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rating_out_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_ratings.size() == 0) begin
					$display("%0t: unexpected result pred %h", $time, prediction);
					errors++;
				end else begin
					e = expected_ratings.pop_front();
					if (prediction !== e.pred) begin
						$display("%0t: prediction exp %h act %h", $time, e.pred, prediction);
						errors++;
					end
					if (residual !== e.res) begin
						$display("%0t: residual exp %h act %h", $time, e.res, residual);
						errors++;
					end
					if (squared_residual !== e.sq) begin
						$display("%0t: squared_residual exp %h act %h", $time, e.sq,
							squared_residual);
						errors++;
					end
					if (out_of_range !== e.oor) begin
						$display("%0t: out_of_range exp %b act %b", $time, e.oor, out_of_range);
						errors++;
					end
					if (saturated !== e.sat) begin
						$display("%0t: saturated exp %b act %b", $time, e.sat, saturated);
						errors++;
					end
				end
			end
			out_ready <= !stall();
		end
	end

	function automatic int rand_q16();
		if ($urandom_range(99) < 80) return int'($urandom_range(131072)) - 65536;
		return int'($urandom());
	endfunction

	function automatic logic [9:0] pick_row(int unsigned lim);
		logic [9:0] r;
		if ($urandom_range(99) < 85) return 10'(rows[$urandom_range(5)]);
		r = 10'($urandom_range(1023));
		if (r < lim) r = 10'(rows[$urandom_range(5)]);
		return r;
	endfunction

	task automatic push_req(logic [1:0] k, logic [9:0] u, logic [9:0] v, logic [31:0] rt,
		logic t, logic [3:0] sl, logic [31:0] fv);
		req_t r;
		r = '{k, u, v, rt, t, sl, fv};
		pending_reqs.push_back(r);
	endtask

	task automatic push_random(int n);
		req_t r;
		int unsigned p, ulim, ilim;
		ulim = users_cfg < USER_ROWS ? users_cfg : USER_ROWS;
		ilim = items_cfg < ITEM_ROWS ? items_cfg : ITEM_ROWS;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			r.tbl = $urandom_range(1);
			r.slot = $urandom_range(15);
			r.fval = rand_q16();
			r.rating = ($urandom_range(99) < 70) ? int'($urandom_range(655360)) - 327680
				: $urandom();
			if (p < 15) begin
				r.kind = KIND_LOAD;
				r.ui = ($urandom_range(1)) ? 10'(rows[$urandom_range(5)])
					: 10'($urandom_range(1023));
				r.ii = 10'($urandom_range(1023));
			end else begin
				r.kind = (p < 20) ? KIND_UNUSED : (p < 65) ? KIND_TRAIN : KIND_PREDICT;
				if (r.kind == KIND_TRAIN) trains++;
				r.ui = pick_row(ulim);
				r.ii = pick_row(ilim);
			end
			pending_reqs.push_back(r);
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_ratings.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ALPHA:  alpha = val;
			REG_LAMBDA: lambda = val;
			REG_NF:     nf_cfg = val & 16'h1f;
			REG_USERS:  users_cfg = val & 16'h7ff;
			default:    items_cfg = val & 16'h7ff;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(logic [15:0] a, logic [15:0] l, logic [15:0] f, logic [15:0] u,
		logic [15:0] v);
		write_reg(REG_ALPHA, a);
		write_reg(REG_LAMBDA, l);
		write_reg(REG_NF, f);
		write_reg(REG_USERS, u);
		write_reg(REG_ITEMS, v);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int t = 0; t < 2; t++)
			foreach (rows[j])
				for (int k = 0; k < MAX_FACTORS; k++)
					push_req(KIND_LOAD, rows[j], 0, 0, t, k, rand_q16());
		push_req(KIND_PREDICT, 0, 0, 0, 0, 0, 0);
		push_req(KIND_PREDICT, 1023, 1023, 32'hffffffff, 1, 15, 32'hffffffff);
		push_req(KIND_TRAIN, 1, 682, 32'h7fffffff, 0, 0, 0);
		push_req(KIND_TRAIN, 341, 2, 32'h80000000, 0, 0, 0);
		push_req(KIND_UNUSED, 1023, 1023, 32'hffffffff, 1, 15, 32'hffffffff);
		push_req(KIND_LOAD, 2, 0, 0, 0, 0, 32'h7fffffff);
		push_req(KIND_LOAD, 2, 0, 0, 1, 0, 32'h80000000);
		push_req(KIND_TRAIN, 2, 2, 32'h7fffffff, 0, 0, 0);
		push_req(KIND_LOAD, 1023, 0, 0, 0, 15, 32'h80000000);
		push_req(KIND_LOAD, 1023, 0, 0, 1, 15, 32'h80000000);
		push_req(KIND_PREDICT, 1023, 1023, 0, 0, 0, 0);
		push_req(KIND_TRAIN, 1023, 1023, 0, 0, 0, 0);
		push_random(200);
		drain();
		set_all(655, 1311, 16, 1024, 1024);
		push_random(200);
		drain();
		set_all(16'hffff, 16'hffff, 31, 2047, 2047);
		push_random(200);
		drain();
		set_all(0, 0, 0, 0, 0);
		push_random(100);
		drain();
		set_all(3000, 500, 1, 1, 1);
		push_random(150);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			set_all($urandom_range(4000), $urandom_range(65535), $urandom_range(1, 16),
				$urandom_range(1, 1024), $urandom_range(1, 1024));
			push_random(40);
			drain();
		end
		$display("covered %0d requests (%0d random trains), %0d results checked, %0d errors",
			accepted, trains, results_seen, errors);
		$display("config phases: defaults, extremes, zero counts, single row, random");
		if (errors == 0)
			$display("biased_mf_sgd_step regression: pass");
		else
			$display("biased_mf_sgd_step regression: fail");
		$finish;
	end

	initial begin
		#40000000;
		$display("biased_mf_sgd_step regression: fail");
		$finish;
	end
endmodule
